[design/psif_pkg.sv]
// ----------------------------------------------------------------------------
// psif_pkg
// Shared types and constants of the pair-sum index finder: table entry
// layout, result codes and hash constants.
// ----------------------------------------------------------------------------
`default_nettype none

package psif_pkg;

    localparam int KEY_W    = 32;   // element and key width
    localparam int IDX_W    = 10;   // stored and reported index width
    localparam int TAG_W    = 8;    // epoch tag width of a table entry
    localparam int HX_W     = 24;   // width of the hashed word before the modulo
    localparam int HX_SHIFT = 8;    // hashed word is the product shifted down by this
    localparam int OUT_W    = 24;   // m_tdata width: two indices padded to bytes

    localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_NONE     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // which key a hash request carries
    localparam logic HK_COMP  = 1'b0;
    localparam logic HK_VALUE = 1'b1;

    typedef struct packed {
        logic vld;
        logic kind;
    } hash_ctl_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } entry_t;

endpackage

`default_nettype wire

[design/psif_table.sv]
// ----------------------------------------------------------------------------
// psif_table
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psif_table #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 50
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/psif_hash.sv]
// ----------------------------------------------------------------------------
// psif_hash
// Four-stage home-slot pipeline: multiplicative hash, then the modulo by the
// table depth through a reciprocal multiply, a back-multiply and a subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module psif_hash #(
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire psif_pkg::hash_ctl_t              in_ctl,
    input  wire logic [psif_pkg::KEY_W-1:0]       in_key,
    output psif_pkg::hash_ctl_t                   out_ctl,
    output logic      [$clog2(DEPTH)-1:0]         out_slot
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int HX_W    = psif_pkg::HX_W;
    localparam int SH      = HX_W + SLOT_W;
    localparam int RECIP_W = HX_W + 1;
    localparam int QP_W    = HX_W + RECIP_W;
    // exact quotient for every HX_W-bit dividend
    localparam longint unsigned RECIP = ((64'd1 << SH) + DEPTH - 1) / DEPTH;

    psif_pkg::hash_ctl_t c1_reg, c2_reg, c3_reg, c4_reg;
    logic [psif_pkg::KEY_W-1:0] h_reg;
    logic [HX_W-1:0]            x2_reg, x3_reg;
    logic [HX_W-1:0]            q_reg;
    logic [HX_W-1:0]            qd_reg;
    logic [SLOT_W-1:0]          slot_reg;

    logic [psif_pkg::KEY_W-1:0] h_next;
    logic [HX_W-1:0]            x1;
    logic [QP_W-1:0]            qp;
    logic [HX_W-1:0]            q_next;
    logic [HX_W-1:0]            qd_next;
    logic [HX_W-1:0]            r;
    logic [SLOT_W-1:0]          slot_next;

    assign h_next  = in_key * psif_pkg::HASH_MULT;
    assign x1      = h_reg[psif_pkg::KEY_W-1:psif_pkg::HX_SHIFT];
    assign qp      = QP_W'(x1) * QP_W'(RECIP);
    assign q_next  = HX_W'(qp >> SH);
    assign qd_next = q_reg * HX_W'(DEPTH);
    assign r       = x3_reg - qd_reg;
    // one correction step keeps the remainder below the depth
    assign slot_next = (r >= HX_W'(DEPTH)) ? SLOT_W'(r - HX_W'(DEPTH)) : SLOT_W'(r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else
        begin
            c1_reg <= in_ctl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        x2_reg   <= x1;
        q_reg    <= q_next;
        x3_reg   <= x2_reg;
        qd_reg   <= qd_next;
        slot_reg <= slot_next;
    end

    assign out_ctl  = c4_reg;
    assign out_slot = slot_reg;

endmodule

`default_nettype wire

[design/pair_sum_index_finder.sv]
// ----------------------------------------------------------------------------
// pair_sum_index_finder
// Two-sum search over a streamed array with an open-addressing hash table
// held in one synchronous RAM, cleared per array through epoch tags.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  s_*      | in        | tdata[31:0] value, tlast is_last
//  m_*      | out       | tdata[9:0] first_index, [19:10] second_index; tuser status
//  cfg_*    | in        | data[31:0] target_sum
//
//  An item hashes its complement and value, probes the table through the
//  single RAM read port for the complement and its insert slot, and emits
//  a result if it gives one; the next item waits. Items after a result are
//  dropped. After reset, and after every 255th array end, a clearing pass
//  over every slot runs with s_tready low. The result waits in an output
//  register; the block stalls only when a second result meets a full one.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_sum_index_finder #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_PROBES  = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [9:0] first_index, [19:10] second_index
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data   // [31:0] target_sum
);

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int WALK    = (MAX_PROBES < TABLE_DEPTH) ? MAX_PROBES : TABLE_DEPTH;
    localparam int PROBE_W = $clog2(WALK + 1);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W   = psif_pkg::KEY_W;
    localparam int IDX_W   = psif_pkg::IDX_W;
    localparam int TAG_W   = psif_pkg::TAG_W;
    localparam int ENT_W   = $bits(psif_pkg::entry_t);

    typedef enum logic [7:0] {
        S_SWEEP  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_FEED_C = 8'b0000_0100,
        S_FEED_V = 8'b0000_1000,
        S_HASH   = 8'b0001_0000,
        S_LOOK   = 8'b0010_0000,
        S_INS    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [KEY_W-1:0]      target_reg, target_next;
    logic [KEY_W-1:0]      value_reg, value_next;
    logic [KEY_W:0]        comp_reg, comp_next;
    logic                  last_reg, last_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  done_reg, done_next;
    logic [TAG_W-1:0]      epoch_reg, epoch_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [SLOT_W-1:0]     home_reg, home_next;
    logic [PROBE_W-1:0]    probe_reg, probe_next;
    logic [SLOT_W-1:0]     sweep_reg, sweep_next;
    psif_pkg::status_t     res_status_reg, res_status_next;
    logic [IDX_W-1:0]      res_first_reg, res_first_next;
    logic [IDX_W-1:0]      res_second_reg, res_second_next;
    logic                  m_valid_reg, m_valid_next;
    psif_pkg::status_t     m_status_reg, m_status_next;
    logic [IDX_W-1:0]      m_first_reg, m_first_next;
    logic [IDX_W-1:0]      m_second_reg, m_second_next;

    psif_pkg::hash_ctl_t   h_in_ctl, h_out_ctl;
    logic [KEY_W-1:0]      h_in_key;
    logic [SLOT_W-1:0]     h_out_slot;

    logic                  wr_en, rd_en;
    logic [SLOT_W-1:0]     wr_addr, rd_addr;
    psif_pkg::entry_t      wr_ent, rd_ent;
    logic [ENT_W-1:0]      rd_raw;

    logic                  in_acc;
    logic                  comp_ok;
    logic                  ent_live;
    logic [SLOT_W-1:0]     slot_inc;
    logic [SLOT_W-1:0]     home_cur;
    logic                  out_free;
    logic                  end_arr;

    psif_hash #(
        .DEPTH (TABLE_DEPTH)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (h_in_ctl),
        .in_key   (h_in_key),
        .out_ctl  (h_out_ctl),
        .out_slot (h_out_slot)
    );

    psif_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENT_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENT_W'(wr_ent)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_ent    = rd_raw;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign comp_ok   = (comp_reg[KEY_W] == comp_reg[KEY_W-1]);
    assign ent_live  = (rd_ent.tag == epoch_reg);
    assign slot_inc  = (slot_reg == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    // value home slot may still sit on the hash output
    assign home_cur  = (h_out_ctl.vld && h_out_ctl.kind == psif_pkg::HK_VALUE) ?
                       h_out_slot : home_reg;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next      = state_reg;
        target_next     = cfg_valid ? cfg_data : target_reg;
        value_next      = value_reg;
        comp_next       = comp_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        done_next       = done_reg;
        epoch_next      = epoch_reg;
        slot_next       = slot_reg;
        home_next       = home_reg;
        probe_next      = probe_reg;
        sweep_next      = sweep_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_second_next = res_second_reg;
        m_valid_next    = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        m_second_next   = m_second_reg;
        h_in_ctl        = '0;
        h_in_key        = comp_reg[KEY_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_ent          = '0;
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        end_arr         = 1'b0;

        if (h_out_ctl.vld && h_out_ctl.kind == psif_pkg::HK_VALUE)
        begin
            home_next = h_out_slot;
        end

        case (state_reg)
            S_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SLOT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_acc)
                begin
                    value_next = s_tdata;
                    last_next  = s_tlast;
                    comp_next  = {target_reg[KEY_W-1], target_reg} -
                                 {s_tdata[KEY_W-1], s_tdata};
                    if (done_reg)
                    begin
                        // drop items after a result
                        end_arr = s_tlast;
                    end
                    else if (count_reg >= COUNT_W'(TABLE_DEPTH))
                    begin
                        res_status_next = psif_pkg::ST_OVERFLOW;
                        res_first_next  = '0;
                        res_second_next = '0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FEED_C;
                    end
                end
            end

            S_FEED_C:
            begin
                h_in_ctl.vld  = 1'b1;
                h_in_ctl.kind = psif_pkg::HK_COMP;
                h_in_key      = comp_reg[KEY_W-1:0];
                state_next    = S_FEED_V;
            end

            S_FEED_V:
            begin
                h_in_ctl.vld  = 1'b1;
                h_in_ctl.kind = psif_pkg::HK_VALUE;
                h_in_key      = value_reg;
                state_next    = S_HASH;
            end

            S_HASH:
            begin
                if (h_out_ctl.vld)
                begin
                    if (h_out_ctl.kind == psif_pkg::HK_COMP && comp_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = h_out_slot;
                        slot_next  = h_out_slot;
                        probe_next = PROBE_W'(1);
                        state_next = S_LOOK;
                    end
                    else if (h_out_ctl.kind == psif_pkg::HK_VALUE)
                    begin
                        // complement out of range: go straight to insert
                        rd_en      = 1'b1;
                        rd_addr    = h_out_slot;
                        slot_next  = h_out_slot;
                        probe_next = PROBE_W'(1);
                        state_next = S_INS;
                    end
                end
            end

            S_LOOK:
            begin
                if (ent_live && rd_ent.key == comp_reg[KEY_W-1:0])
                begin
                    res_status_next = psif_pkg::ST_FOUND;
                    res_first_next  = rd_ent.idx;
                    res_second_next = IDX_W'(count_reg);
                    state_next      = S_EMIT;
                end
                else if (!ent_live || probe_reg == PROBE_W'(WALK))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = home_cur;
                    slot_next  = home_cur;
                    probe_next = PROBE_W'(1);
                    state_next = S_INS;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_inc;
                    slot_next  = slot_inc;
                    probe_next = probe_reg + 1'b1;
                end
            end

            S_INS:
            begin
                if (!ent_live || rd_ent.key == value_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = slot_reg;
                    wr_ent.tag = epoch_reg;
                    wr_ent.key = value_reg;
                    wr_ent.idx = IDX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                    if (last_reg)
                    begin
                        res_status_next = psif_pkg::ST_NONE;
                        res_first_next  = '0;
                        res_second_next = '0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (probe_reg == PROBE_W'(WALK))
                begin
                    res_status_next = psif_pkg::ST_OVERFLOW;
                    res_first_next  = '0;
                    res_second_next = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_inc;
                    slot_next  = slot_inc;
                    probe_next = probe_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_first_next  = res_first_reg;
                    m_second_next = res_second_reg;
                    done_next     = 1'b1;
                    end_arr       = last_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // close the array: advance the epoch, sweep when the tags run out
        if (end_arr)
        begin
            count_next = '0;
            done_next  = 1'b0;
            if (&epoch_reg)
            begin
                epoch_next = TAG_W'(1);
                sweep_next = '0;
                state_next = S_SWEEP;
            end
            else
            begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_SWEEP;
            target_reg  <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            epoch_reg   <= TAG_W'(1);
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            target_reg  <= target_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            epoch_reg   <= epoch_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        comp_reg       <= comp_next;
        last_reg       <= last_next;
        slot_reg       <= slot_next;
        home_reg       <= home_next;
        probe_reg      <= probe_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
        m_second_reg   <= m_second_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = psif_pkg::OUT_W'({m_second_reg, m_first_reg});
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

[design/psif_check.sv]
// ----------------------------------------------------------------------------
// psif_check
// Port-level checks of the pair-sum index finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psif_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [31:0] cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    // only a found pair carries indices
    a_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'(psif_pkg::ST_FOUND) |-> m_tdata == 24'd0)
        else $error("indices set on a result without a pair");

    // handshake outputs are always driven out of reset
    a_known_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tready, m_tvalid, cfg_ready}))
        else $error("handshake output unknown");

    // offered items and register writes carry defined data
    a_known_in: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tvalid || !$isunknown({s_tdata, s_tlast})) &&
        (!cfg_valid || !$isunknown(cfg_data)))
        else $error("offered data unknown");

endmodule

bind pair_sum_index_finder psif_check u_psif_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire

[tb/pair_sum_index_finder_tb.sv]
// ----------------------------------------------------------------------------
// pair_sum_index_finder_tb
// Streams arrays of signed numbers through the pair-sum index finder and checks
// every status/index item against an in-bench hash-table model, across several
// target sums, a table overflow array, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_sum_index_finder_tb;

    localparam int TBL_DEPTH     = 1024;
    localparam int PROBE_LIMIT   = 1024;
    localparam int SLOT_W        = $clog2(TBL_DEPTH);
    localparam int WALK_LIMIT    = (PROBE_LIMIT < TBL_DEPTH) ? PROBE_LIMIT : TBL_DEPTH;
    localparam int SETTLE_CYCLES = 2 * WALK_LIMIT + 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int LIMIT_CYCLES  = 5_000_000;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } search_item_t;

    typedef struct packed {
        psif_pkg::status_t          status;
        logic [psif_pkg::IDX_W-1:0] first;
        logic [psif_pkg::IDX_W-1:0] second;
    } search_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // model of the search table and array progress
    logic [31:0]                slot_key [TBL_DEPTH];
    logic [psif_pkg::IDX_W-1:0] slot_idx [TBL_DEPTH];
    bit                         slot_used [TBL_DEPTH];
    int unsigned                arr_count = 0;
    bit                         arr_closed = 1'b0;
    logic [31:0]                cur_target = '0;

    search_item_t   elem_feed [$];
    search_result_t expected_results [$];

    int unsigned src_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatches = 0;
    int unsigned items_accepted = 0;
    int unsigned arrays_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned pairs_seen = 0;
    int unsigned overflows_seen = 0;

    pair_sum_index_finder #(
        .TABLE_DEPTH(TBL_DEPTH),
        .MAX_PROBES (PROBE_LIMIT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] value
        .s_tlast  (s_tlast),    // is_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [9:0] first_index, [19:10] second_index
        .m_tuser  (m_tuser),    // [1:0] status
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)    // [31:0] target_sum
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("pair_sum_index_finder verification failed");
        $finish;
    end

    function automatic int unsigned slot_hash(logic [31:0] key);
        logic [31:0] prod;
        prod = key * psif_pkg::HASH_MULT;
        return (prod >> psif_pkg::HX_SHIFT) % TBL_DEPTH;
    endfunction

    // negative key whose home slot is the given one: fills the table with one
    // probe per insert, and with a maximal target its complement is out of range
    function automatic logic [31:0] neg_key_at_slot(int unsigned slot);
        logic [31:0] inv;
        logic [31:0] prod;
        logic [31:0] v;
        inv = psif_pkg::HASH_MULT;
        repeat (5) inv = inv * (32'd2 - psif_pkg::HASH_MULT * inv);
        do
        begin
            prod = $urandom;
            prod[psif_pkg::HX_SHIFT +: SLOT_W] = slot[SLOT_W-1:0];
            v = prod * inv;
        end while (!v[31]);
        return v;
    endfunction

    task automatic predict_search(input logic [31:0] v, input logic last);
        logic signed [32:0]         comp;
        int unsigned                s;
        bit                         hit;
        bit                         placed;
        logic [psif_pkg::IDX_W-1:0] earlier;
        hit = 1'b0;
        placed = 1'b0;
        earlier = '0;
        if (!arr_closed)
        begin
            if (arr_count >= TBL_DEPTH)
            begin
                expected_results.push_back('{status: psif_pkg::ST_OVERFLOW,
                                             first: '0, second: '0});
                arr_closed = 1'b1;
            end
            else
            begin
                comp = {cur_target[31], cur_target} - {v[31], v};
                // a complement outside 32-bit range can never be in the table
                if (comp[32] == comp[31])
                begin
                    s = slot_hash(comp[31:0]);
                    for (int p = 0; p < WALK_LIMIT; p++)
                    begin
                        if (!slot_used[s])
                            break;
                        if (slot_key[s] == comp[31:0])
                        begin
                            hit = 1'b1;
                            earlier = slot_idx[s];
                            break;
                        end
                        s = (s + 1) % TBL_DEPTH;
                    end
                end
                if (hit)
                begin
                    expected_results.push_back('{status: psif_pkg::ST_FOUND, first: earlier,
                                                 second: psif_pkg::IDX_W'(arr_count)});
                    arr_closed = 1'b1;
                end
                else
                begin
                    s = slot_hash(v);
                    for (int p = 0; p < WALK_LIMIT; p++)
                    begin
                        if (!slot_used[s] || slot_key[s] == v)
                        begin
                            slot_used[s] = 1'b1;
                            slot_key[s] = v;
                            slot_idx[s] = psif_pkg::IDX_W'(arr_count);
                            placed = 1'b1;
                            break;
                        end
                        s = (s + 1) % TBL_DEPTH;
                    end
                    if (placed)
                        arr_count++;
                    else
                    begin
                        expected_results.push_back('{status: psif_pkg::ST_OVERFLOW,
                                                     first: '0, second: '0});
                        arr_closed = 1'b1;
                    end
                end
            end
            if (!arr_closed && last)
            begin
                expected_results.push_back('{status: psif_pkg::ST_NONE,
                                             first: '0, second: '0});
                arr_closed = 1'b1;
            end
        end
        if (last)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            arr_count = 0;
            arr_closed = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // sender: present the next pending item, hold it until taken
    always @(posedge clk)
    begin
        search_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_search(s_tdata, s_tlast);
                items_accepted++;
                if (s_tlast)
                    arrays_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (elem_feed.size() != 0 && $urandom_range(99) >= src_gap_pct)
                begin
                    nxt = elem_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.value;
                    s_tlast <= nxt.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted down on its own
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: take results and compare against the oldest expectation
    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tuser == psif_pkg::ST_FOUND)
                    pairs_seen++;
                if (m_tuser == psif_pkg::ST_OVERFLOW)
                    overflows_seen++;
                if (expected_results.size() == 0)
                    flag_mismatch($sformatf("unexpected result status %0d idx %0d/%0d",
                                            m_tuser, m_tdata[9:0], m_tdata[19:10]));
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                m_tuser, want.status));
                    if (m_tdata[9:0] !== want.first)
                        flag_mismatch($sformatf("first_index %0d, want %0d",
                                                m_tdata[9:0], want.first));
                    if (m_tdata[19:10] !== want.second)
                        flag_mismatch($sformatf("second_index %0d, want %0d",
                                                m_tdata[19:10], want.second));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic push_item(input logic [31:0] v, input logic last);
        elem_feed.push_back('{value: v, last: last});
    endtask

    task automatic write_target(input logic [31:0] t);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= t;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_target = t;
    endtask

    // wait for every item to be taken and every result to arrive, then let
    // any walk still in flight finish
    task automatic drain_phase();
        while (elem_feed.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random arrays: mostly built to produce pairs and duplicates, some pure noise
    task automatic queue_search_arrays(input int unsigned n);
        logic [31:0] vals [$];
        logic [31:0] v;
        int unsigned len;
        int unsigned pick;
        int unsigned queued;
        bit          noise;
        queued = 0;
        while (queued < n)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
            noise = ($urandom_range(4) == 0);
            vals.delete();
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(99);
                if (noise)
                    v = $urandom;
                else if (vals.size() != 0 && pick < 35)
                    v = cur_target - vals[$urandom_range(vals.size() - 1)];
                else if (vals.size() != 0 && pick < 50)
                    v = vals[$urandom_range(vals.size() - 1)];
                else if (pick < 75)
                    v = 32'($urandom_range(16)) - 32'd8;
                else
                    v = $urandom;
                vals.push_back(v);
                push_item(v, i == len - 1);
            end
            queued += len;
        end
    endtask

    initial
    begin
        logic [31:0] a;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        src_gap_pct = 25;
        sink_stall_pct = 71;

        // small target: hit on last, no pair, lone element, duplicate overwrite
        write_target(32'd10);
        push_item(32'd3, 1'b0);
        push_item(32'd4, 1'b0);
        push_item(32'd7, 1'b1);
        push_item(32'd1, 1'b0);
        push_item(32'd2, 1'b0);
        push_item(32'd3, 1'b1);
        push_item(32'd5, 1'b1);
        push_item(32'd6, 1'b0);
        push_item(32'd6, 1'b0);
        push_item(32'd4, 1'b0);
        push_item(32'd9, 1'b0);
        push_item(32'd4, 1'b1);
        drain_phase();

        // maximal target: value extremes, then an array longer than the table
        write_target(32'h7FFF_FFFF);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b1);
        for (int k = 0; k < TBL_DEPTH; k++)
            push_item(neg_key_at_slot(k), 1'b0);
        repeat (3) push_item($urandom | 32'h8000_0000, 1'b0);
        push_item(32'hFFFF_FFFB, 1'b1);
        drain_phase();

        // minimal target: complement below range, then a pair reaching it
        write_target(32'h8000_0000);
        push_item(32'd1, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        push_item(32'd0, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        drain_phase();

        // short pair arrays while the receiver holds off, so results back up
        write_target($urandom);
        repeat (40)
        begin
            a = $urandom_range(1000);
            push_item(a, 1'b0);
            push_item(cur_target - a, 1'b1);
        end
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        queue_search_arrays(150);
        drain_phase();

        src_gap_pct = 71;
        sink_stall_pct = 25;
        write_target(32'hFFFF_FFFF);
        queue_search_arrays(150);
        drain_phase();
        write_target(32'd0);
        queue_search_arrays(150);
        drain_phase();

        src_gap_pct = 0;
        sink_stall_pct = 0;
        write_target($urandom);
        queue_search_arrays(150);
        drain_phase();

        $display("Covered %0d items in %0d arrays over seven target sums.",
                 items_accepted, arrays_accepted);
        $display("Checked %0d results: %0d pairs, %0d table overflows, %0d mismatches.",
                 results_seen, pairs_seen, overflows_seen, mismatches);
        if (mismatches == 0)
            $display("pair_sum_index_finder verification clean");
        else
            $display("pair_sum_index_finder verification failed");
        $finish;
    end

endmodule

`default_nettype wire
